>>> sv/rbp_pkg.sv
package rbp_pkg;

  // Default limits, handed down from the top level
  localparam int DEF_MAX_DEPTH     = 65535;
  localparam int DEF_MAX_INDEL_LEN = 1023;

  // Depth of the result queue: it takes up to two words per item
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // ASCII codes used by the parser
  localparam logic [7:0] CH_PLUS   = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS  = 8'h2D;  // '-'
  localparam logic [7:0] CH_CARET  = 8'h5E;  // '^'
  localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
  localparam logic [7:0] CH_0      = 8'h30;  // '0'
  localparam logic [7:0] CH_9      = 8'h39;  // '9'
  localparam logic [7:0] CH_UA     = 8'h41;  // 'A'
  localparam logic [7:0] CH_UC     = 8'h43;  // 'C'
  localparam logic [7:0] CH_UG     = 8'h47;  // 'G'
  localparam logic [7:0] CH_UT     = 8'h54;  // 'T'
  localparam logic [7:0] CH_LA     = 8'h61;  // 'a'
  localparam logic [7:0] CH_LC     = 8'h63;  // 'c'
  localparam logic [7:0] CH_LG     = 8'h67;  // 'g'
  localparam logic [7:0] CH_LT     = 8'h74;  // 't'

  // Strand codes
  localparam logic [1:0] STRAND_FWD     = 2'd0;
  localparam logic [1:0] STRAND_REV     = 2'd1;
  localparam logic [1:0] STRAND_UNKNOWN = 2'd2;

  // Result kinds
  localparam logic KIND_BASE    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Parser modes
  typedef enum logic [3:0] {
    MODE_NORMAL = 4'b0001,
    MODE_DIGITS = 4'b0010,
    MODE_SKIP   = 4'b0100,
    MODE_CARET  = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [7:0]  symbol;
    logic        line_end;
    logic [15:0] expected_count;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  base;
    logic [1:0]  strand;
    logic [15:0] base_index;
    logic        start_seen;
    logic        end_seen;
    logic        count_error;
    logic        last;
  } out_word_t;

  // Words handed from the parser to the result queue in one cycle
  typedef struct packed {
    logic [1:0] cnt;
    out_word_t  first;
    out_word_t  second;
  } push_t;

endpackage

>>> sv/rbp_parse.sv
module rbp_parse #(
  parameter int MAX_DEPTH     = rbp_pkg::DEF_MAX_DEPTH,
  parameter int MAX_INDEL_LEN = rbp_pkg::DEF_MAX_INDEL_LEN
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rbp_pkg::in_word_t in_word,
  input  logic              room,
  output rbp_pkg::push_t    push
);
  import rbp_pkg::*;

  localparam int SKIP_W = $clog2(MAX_INDEL_LEN + 1);
  localparam logic [SKIP_W-1:0] SKIP_MAX = SKIP_W'(MAX_INDEL_LEN);
  localparam logic [15:0] CNT_LIM = (MAX_DEPTH > 65535) ? 16'hFFFF : 16'(MAX_DEPTH);

  // Input register
  logic     in_valid_r;
  in_word_t in_word_r;
  logic     adv;

  // Line state
  mode_t             mode_r, mode_nxt;
  logic [SKIP_W-1:0] skip_r, skip_nxt;
  logic [15:0]       cnt_r, cnt_nxt;
  logic              start_r, start_nxt;
  logic              end_r, end_nxt;
  logic [1:0]        strand_r, strand_nxt;
  logic              over_r, over_nxt;

  logic              keep;
  logic              do_normal;
  logic              is_digit;
  logic [3:0]        digit;
  logic [SKIP_W+3:0] acc;
  logic [SKIP_W-1:0] skip_dec;
  logic [1:0]        strand_sel;
  out_word_t         base_res, sum_res;

  assign adv      = in_valid_r && room;
  assign in_stall = in_valid_r && !room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_word_r <= in_word;
    end
  end

  // Indel length digit and accumulate (length*10 + digit)
  assign is_digit = (in_word_r.symbol >= CH_0) && (in_word_r.symbol <= CH_9);
  assign digit    = 4'(in_word_r.symbol - CH_0);
  assign acc      = ({4'b0000, skip_r} << 3) + ({4'b0000, skip_r} << 1)
                  + {{SKIP_W{1'b0}}, digit};
  assign skip_dec = skip_r - 1'b1;

  // Mode step
  always_comb begin
    mode_nxt   = mode_r;
    skip_nxt   = skip_r;
    start_nxt  = start_r;
    end_nxt    = end_r;
    strand_nxt = strand_r;
    cnt_nxt    = cnt_r;
    over_nxt   = over_r;
    keep       = 1'b0;
    do_normal  = 1'b0;
    strand_sel = strand_r;

    unique case (mode_r)
      MODE_DIGITS: begin
        if (is_digit) begin
          skip_nxt = (acc > {4'b0000, SKIP_MAX}) ? SKIP_MAX : acc[SKIP_W-1:0];
        end else if (skip_r == '0) begin
          // sign without digits: this byte is parsed as normal
          mode_nxt  = MODE_NORMAL;
          do_normal = 1'b1;
        end else begin
          skip_nxt = skip_dec;
          mode_nxt = (skip_dec == '0) ? MODE_NORMAL : MODE_SKIP;
        end
      end
      MODE_SKIP: begin
        if (skip_r != '0) begin
          skip_nxt = skip_dec;
        end
        if (skip_r == '0 || skip_dec == '0) begin
          mode_nxt = MODE_NORMAL;
        end
      end
      MODE_CARET: begin
        mode_nxt = MODE_NORMAL;
      end
      MODE_NORMAL: begin
        do_normal = 1'b1;
      end
      default: begin
        mode_nxt = MODE_NORMAL;
      end
    endcase

    // Normal-mode byte classes
    if (do_normal) begin
      priority if (in_word_r.symbol == CH_PLUS || in_word_r.symbol == CH_MINUS) begin
        mode_nxt = MODE_DIGITS;
        skip_nxt = '0;
      end else if (in_word_r.symbol == CH_CARET) begin
        mode_nxt  = MODE_CARET;
        start_nxt = 1'b1;
      end else if (in_word_r.symbol == CH_DOLLAR) begin
        end_nxt = 1'b1;
      end else begin
        keep = 1'b1;
      end
    end

    // Kept base: strand and count
    if (keep) begin
      priority if (in_word_r.symbol == CH_UA || in_word_r.symbol == CH_UC ||
                   in_word_r.symbol == CH_UG || in_word_r.symbol == CH_UT) begin
        strand_sel = STRAND_FWD;
      end else if (in_word_r.symbol == CH_LA || in_word_r.symbol == CH_LC ||
                   in_word_r.symbol == CH_LG || in_word_r.symbol == CH_LT) begin
        strand_sel = STRAND_REV;
      end else begin
        strand_sel = strand_r;
      end
      strand_nxt = strand_sel;
      if (cnt_r < CNT_LIM) begin
        cnt_nxt = cnt_r + 16'd1;
      end else begin
        over_nxt = 1'b1;
      end
    end
  end

  // Result words
  always_comb begin
    base_res             = '0;
    base_res.kind        = KIND_BASE;
    base_res.base        = in_word_r.symbol;
    base_res.strand      = strand_sel;
    base_res.base_index  = cnt_r;

    sum_res              = '0;
    sum_res.kind         = KIND_SUMMARY;
    sum_res.base_index   = cnt_nxt;
    sum_res.start_seen   = start_nxt;
    sum_res.end_seen     = end_nxt;
    sum_res.count_error  = over_nxt || (cnt_nxt != in_word_r.expected_count);
    sum_res.last         = 1'b1;

    push        = '0;
    push.first  = keep ? base_res : sum_res;
    push.second = sum_res;
    if (adv) begin
      push.cnt = 2'({1'b0, keep} + {1'b0, in_word_r.line_end});
    end
  end

  // State registers; end of line returns everything to its reset value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_NORMAL;
      skip_r   <= '0;
      cnt_r    <= '0;
      start_r  <= 1'b0;
      end_r    <= 1'b0;
      strand_r <= STRAND_UNKNOWN;
      over_r   <= 1'b0;
    end else if (adv) begin
      if (in_word_r.line_end) begin
        mode_r   <= MODE_NORMAL;
        skip_r   <= '0;
        cnt_r    <= '0;
        start_r  <= 1'b0;
        end_r    <= 1'b0;
        strand_r <= STRAND_UNKNOWN;
        over_r   <= 1'b0;
      end else begin
        mode_r   <= mode_nxt;
        skip_r   <= skip_nxt;
        cnt_r    <= cnt_nxt;
        start_r  <= start_nxt;
        end_r    <= end_nxt;
        strand_r <= strand_nxt;
        over_r   <= over_nxt;
      end
    end
  end

endmodule

>>> sv/rbp_queue.sv
module rbp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  rbp_pkg::push_t     push,
  output logic               room,
  output logic               out_valid,
  input  logic               out_stall,
  output rbp_pkg::out_word_t out_word
);
  import rbp_pkg::*;

  out_word_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_inc;
  logic [QCNT_W-1:0] count_r, avail;
  logic              pop;

  assign pop        = out_valid && !out_stall;
  assign avail      = count_r - QCNT_W'(pop);
  // room for two words after this cycle's pop
  assign room       = avail <= QCNT_W'(QUEUE_DEPTH - 2);
  assign out_valid  = count_r != '0;
  assign out_word   = mem_r[rd_ptr_r];
  assign wr_ptr_inc = wr_ptr_r + 1'b1;

  // Storage
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_inc] <= push.second;
    end
  end

  // Pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPTR_W'(push.cnt);
      rd_ptr_r <= rd_ptr_r + QPTR_W'(pop);
      count_r  <= avail + QCNT_W'(push.cnt);
    end
  end

endmodule

>>> sv/pileup_read_base_parser_unit.sv
// Channel  Direction  Word type    Handshake
// in_      input      in_word_t    in_valid / in_stall
// out_     output     out_word_t   out_valid / out_stall
//
// One byte can be taken every cycle while in_stall is low; it is held in the input register,
// then its result words are written to the result queue, which shows them on out_.
// A kept base on the last byte of a line gives two words (base, then summary), so such
// bytes put two words on out_; a four-word result queue absorbs them.
// in_stall rises while a byte waits in the input register and the queue would hold more
// than two words after the current pop.
// rst_n is synchronous and active low; it clears the line state and empties the queue.
module pileup_read_base_parser_unit #(
  parameter int MAX_DEPTH     = rbp_pkg::DEF_MAX_DEPTH,
  parameter int MAX_INDEL_LEN = rbp_pkg::DEF_MAX_INDEL_LEN
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rbp_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output rbp_pkg::out_word_t out_word
);
  import rbp_pkg::*;

  push_t push;
  logic  room;

  // Byte parser with its input register
  rbp_parse #(
    .MAX_DEPTH     (MAX_DEPTH),
    .MAX_INDEL_LEN (MAX_INDEL_LEN)
  ) u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .room     (room),
    .push     (push)
  );

  // Result queue
  rbp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

>>> sv/rbp_checker.sv
module rbp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input rbp_pkg::in_word_t  in_word,
  input logic               out_valid,
  input logic               out_stall,
  input rbp_pkg::out_word_t out_word
);
  import rbp_pkg::*;

  // Reset empties the output side
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word shown just after reset");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  // Summary words carry no base and close the line
  a_summary_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.kind == KIND_SUMMARY |->
      out_word.last && out_word.base == 8'd0 && out_word.strand == STRAND_FWD)
    else $error("malformed summary word");

  // Base words carry no summary flags and a legal strand
  a_base_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.kind == KIND_BASE |->
      !out_word.last && !out_word.start_seen && !out_word.end_seen &&
      !out_word.count_error && out_word.strand != 2'd3)
    else $error("malformed base word");

endmodule

bind pileup_read_base_parser_unit rbp_checker u_rbp_checker (.*);

>>> tb/pileup_read_base_parser_unit_test.sv
`timescale 1ns / 1ps

module pileup_read_base_parser_unit_test;
  import rbp_pkg::*;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 900;
  localparam int INDEL_CAP     = DEF_MAX_INDEL_LEN;
  localparam int COUNT_CAP     = (DEF_MAX_DEPTH > 65535) ? 65535 : DEF_MAX_DEPTH;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  pileup_read_base_parser_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // Words the parser owes us, oldest first
  out_word_t pending_words[$];

  // Line parser state, mirrored
  mode_t      line_mode;
  int         indel_left;
  int         kept_bases;
  logic       caret_seen;
  logic       dollar_seen;
  logic       depth_overflow;
  logic [1:0] prev_strand;

  // Random line under construction
  logic [7:0] line_bytes[$];
  int         line_guess;
  string      base_chars = "ACGTacgtNn.,*";

  int  error_count;
  int  sent_items;
  int  words_checked;
  int  lines_checked;
  int  cycle_count;
  int  holdoff_left;
  bit  in_gaps;
  bit  out_gaps;

  // Clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words still owed", cycle_count,
               pending_words.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Expected-result generation
  // ---------------------------------------------------------------------------

  task clear_line_state;
    line_mode      = MODE_NORMAL;
    indel_left     = 0;
    kept_bases     = 0;
    caret_seen     = 1'b0;
    dollar_seen    = 1'b0;
    depth_overflow = 1'b0;
    prev_strand    = STRAND_UNKNOWN;
  endtask

  // Queue one expected word behind those already owed
  task owe_word(input out_word_t w);
    pending_words = {pending_words, w};
  endtask

  // Normal-mode byte; returns 1 when the byte is a kept base
  function logic take_plain(input logic [7:0] c);
    if (c == CH_PLUS || c == CH_MINUS) begin
      line_mode  = MODE_DIGITS;
      indel_left = 0;
      return 1'b0;
    end
    if (c == CH_CARET) begin
      line_mode  = MODE_CARET;
      caret_seen = 1'b1;
      return 1'b0;
    end
    if (c == CH_DOLLAR) begin
      dollar_seen = 1'b1;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task parse_symbol(input in_word_t w);
    out_word_t  r;
    logic       keep;
    logic [1:0] s;
    int         v;
    keep = 1'b0;
    case (line_mode)
      MODE_DIGITS: begin
        if (w.symbol >= CH_0 && w.symbol <= CH_9) begin
          v = indel_left * 10 + int'(w.symbol - CH_0);
          indel_left = (v > INDEL_CAP) ? INDEL_CAP : v;
        end else if (indel_left == 0) begin
          // sign with no length: byte is parsed as usual
          line_mode = MODE_NORMAL;
          keep = take_plain(w.symbol);
        end else begin
          indel_left--;
          line_mode = (indel_left == 0) ? MODE_NORMAL : MODE_SKIP;
        end
      end
      MODE_SKIP: begin
        if (indel_left > 0) indel_left--;
        if (indel_left == 0) line_mode = MODE_NORMAL;
      end
      MODE_CARET: line_mode = MODE_NORMAL;
      default: keep = take_plain(w.symbol);
    endcase

    if (keep) begin
      s = prev_strand;
      if (w.symbol == CH_UA || w.symbol == CH_UC || w.symbol == CH_UG || w.symbol == CH_UT)
        s = STRAND_FWD;
      else if (w.symbol == CH_LA || w.symbol == CH_LC || w.symbol == CH_LG ||
               w.symbol == CH_LT)
        s = STRAND_REV;
      prev_strand = s;
      r = '0;
      r.kind       = KIND_BASE;
      r.base       = w.symbol;
      r.strand     = s;
      r.base_index = kept_bases[15:0];
      owe_word(r);
      if (kept_bases < COUNT_CAP) kept_bases++;
      else depth_overflow = 1'b1;
    end

    // Line summary; any half-read marker is dropped
    if (w.line_end) begin
      r = '0;
      r.kind        = KIND_SUMMARY;
      r.base_index  = kept_bases[15:0];
      r.start_seen  = caret_seen;
      r.end_seen    = dollar_seen;
      r.count_error = depth_overflow || (kept_bases != int'(w.expected_count));
      r.last        = 1'b1;
      owe_word(r);
      clear_line_state();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Offer one word at the falling edge and hold it until taken
  task send_word(input logic [7:0] sym, input logic le, input logic [15:0] want);
    in_word_t w;
    w.symbol         = sym;
    w.line_end       = le;
    w.expected_count = want;
    @(negedge clk);
    while (in_gaps && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    parse_symbol(w);
    sent_items++;
    do @(posedge clk); while (in_stall);
  endtask

  // Sends a text; the last byte closes the line if asked
  task send_text(input string s, input bit close, input logic [15:0] want);
    for (int i = 0; i < s.len(); i++)
      send_word(s[i], close && (i == s.len() - 1), want);
  endtask

  // Stop offering and let every owed word come out
  task wait_for_results;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function logic [7:0] pick_base();
    return base_chars[$urandom_range(0, base_chars.len() - 1)];
  endfunction

  // Output stall: random, or a counted hold-off when requested
  always @(negedge clk) begin
    if (holdoff_left > 0) begin
      out_stall <= 1'b1;
      holdoff_left--;
    end else begin
      out_stall <= out_gaps && ($urandom_range(0, 99) < 33);
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    if (error_count < 30)
      $display("MISMATCH at cycle %0d, %s: got 0x%0h, want 0x%0h", cycle_count, what, got,
               want);
    error_count++;
  endtask

  task check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  always @(posedge clk) begin
    out_word_t want_w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        report_mismatch("word with nothing owed", 32'(out_word), 32'd0);
      end else begin
        want_w = pending_words.pop_front();
        words_checked++;
        if (want_w.kind == KIND_SUMMARY) lines_checked++;
        check_field("kind",        32'(out_word.kind),        32'(want_w.kind));
        check_field("base",        32'(out_word.base),        32'(want_w.base));
        check_field("strand",      32'(out_word.strand),      32'(want_w.strand));
        check_field("base_index",  32'(out_word.base_index),  32'(want_w.base_index));
        check_field("start_seen",  32'(out_word.start_seen),  32'(want_w.start_seen));
        check_field("end_seen",    32'(out_word.end_seen),    32'(want_w.end_seen));
        check_field("count_error", 32'(out_word.count_error), 32'(want_w.count_error));
        check_field("last",        32'(out_word.last),        32'(want_w.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Markers, both strands, odd bytes and lines cut mid-marker
  task test_directed;
    // caret with quality, unknown then known strand, dollar closing the line
    send_text("^].,c*A$", 1'b1, 16'd5);
    // indels of both signs, line ends on a kept base
    send_text("+2GTa-1cT", 1'b1, 16'd0);
    // extreme bytes, sign without digits
    send_word(8'hFF, 1'b0, 16'h5A5A);
    send_word(CH_MINUS, 1'b0, 16'hA5A5);
    send_word(CH_UG, 1'b0, 16'h0000);
    send_word(8'h00, 1'b1, 16'hFFFF);
    // line ends while reading the length, then after a caret
    send_text("+3", 1'b1, 16'd0);
    send_text("^", 1'b1, 16'd0);
    send_text("$", 1'b1, 16'd1);
    wait_for_results();
  endtask

  // Length capping, zero length and line ending mid-skip
  task test_indel_lengths;
    // capped length outlasts the line, so the rest of it is skipped
    send_text("+12345", 1'b0, 16'd0);
    repeat (100) send_word(8'($urandom_range(0, 255)), 1'b0, 16'($urandom));
    send_text("A", 1'b1, 16'd0);
    send_text("+0G", 1'b1, 16'd1);
    send_text("-10", 1'b0, 16'd0);
    repeat (10) send_word(8'($urandom_range(0, 255)), 1'b0, 16'($urandom));
    send_text("a$", 1'b1, 16'd1);
    send_text("+5AC", 1'b1, 16'd0);
    wait_for_results();
  endtask

  // Receiver holds off while the sender keeps pushing
  task test_backpressure;
    in_gaps = 1'b0;
    holdoff_left = 150;
    repeat (40) send_word(pick_base(), 1'b0, 16'($urandom));
    send_word(CH_UA, 1'b1, 16'd41);
    in_gaps = 1'b1;
    wait_for_results();
  endtask

  task add_byte(input logic [7:0] b);
    line_bytes = {line_bytes, b};
  endtask

  task build_random_line;
    int    r;
    int    len;
    int    n_bases;
    string digits;
    line_bytes.delete();
    line_guess = 0;
    repeat ($urandom_range(1, 16)) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        add_byte(pick_base());
        line_guess++;
      end else if (r < 60) begin
        add_byte(CH_CARET);
        add_byte(8'($urandom_range(0, 255)));
      end else if (r < 67) begin
        add_byte(CH_DOLLAR);
      end else if (r < 88) begin
        len = $urandom_range(0, 12);
        add_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
        if ($urandom_range(0, 9) == 0) begin
          len = 0;  // bare sign
        end else begin
          if ($urandom_range(0, 7) == 0) add_byte(CH_0);
          digits = $sformatf("%0d", len);
          for (int i = 0; i < digits.len(); i++) add_byte(digits[i]);
        end
        // now and then the indel is cut short
        n_bases = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : len;
        repeat (n_bases) add_byte(pick_base());
      end else begin
        add_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task send_random_line;
    int         r;
    logic [15:0] want;
    r = $urandom_range(0, 99);
    if (r < 50)      want = 16'(line_guess);
    else if (r < 60) want = 16'(line_guess + 1);
    else if (r < 70) want = 16'(line_guess - 1);
    else             want = 16'($urandom);
    for (int i = 0; i < line_bytes.size(); i++) begin
      if (i == line_bytes.size() - 1) send_word(line_bytes[i], 1'b1, want);
      else send_word(line_bytes[i], 1'b0, 16'($urandom));
    end
  endtask

  // Mostly well-formed lines with random content, some noise
  task test_random_lines;
    int line_no;
    int first_item;
    line_no    = 0;
    first_item = sent_items;
    while (sent_items - first_item < RANDOM_ITEMS) begin
      build_random_line();
      in_gaps  = !(line_no >= 10 && line_no < 25);
      out_gaps = in_gaps;
      send_random_line();
      if (line_no == 30) wait_for_results();
      line_no++;
    end
    in_gaps  = 1'b1;
    out_gaps = 1'b1;
    wait_for_results();
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_word      = '0;
    out_stall    = 1'b0;
    holdoff_left = 0;
    in_gaps      = 1'b1;
    out_gaps     = 1'b1;
    error_count  = 0;
    sent_items   = 0;
    cycle_count  = 0;
    clear_line_state();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_indel_lengths();
    test_backpressure();
    test_random_lines();

    $display("Sent %0d bytes, checked %0d result words across %0d lines", sent_items,
             words_checked, lines_checked);
    $display("Covered markers, capped and bare indel lengths, back-pressure and random lines");
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
